// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers of the sha-256 byte hasher rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside of reset
`define SHB_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside of reset
`define SHB_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/shb_pkg.sv =====
// ---------------------------------------------------------------------------
// shb_pkg
// types, constants and helper functions of the sha-256 byte hasher
// ---------------------------------------------------------------------------
package shb_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_BYTE       = 8'h80;
    localparam logic [5:0] LEN_START_FILL = 6'd56;
    localparam logic [5:0] LAST_FILL      = 6'd63;
    localparam logic [5:0] LAST_ROUND     = 6'd63;
    localparam logic [2:0] LAST_WORD      = 3'd7;
    localparam logic [2:0] LAST_LEN_BYTE  = 3'd7;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_en;
        logic       hash_init;
        logic [2:0] rd_idx;
    } t_core_ctl;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/shb_core.sv =====
// ---------------------------------------------------------------------------
// shb_core
// sha-256 round unit: byte window, message schedule, working vars, hash
// ---------------------------------------------------------------------------
module shb_core
    import shb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    output logic [31:0] o_hash_word
);

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];

    logic [31:0] src [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] w_new;

    // round 0 starts from the hash words
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            src[i] = (i_ctl.round_idx == '0) ? r_h[i] : r_v[i];
        end
        ch    = (src[4] & src[5]) ^ (~src[4] & src[6]);
        maj   = (src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]);
        t1    = src[7] + big_sigma1(src[4]) + ch + ROUND_K[i_ctl.round_idx] + r_w[0];
        t2    = big_sigma0(src[0]) + maj;
        w_new = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    end

    // schedule window, bytes enter at the top (r_w[15]), words leave at the bottom (r_w[0])
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctl.byte_val};
        end else if (i_ctl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.round_en) begin
            r_v[7] <= src[6];
            r_v[6] <= src[5];
            r_v[5] <= src[4];
            r_v[4] <= src[3] + t1;
            r_v[3] <= src[2];
            r_v[2] <= src[1];
            r_v[1] <= src[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.hash_init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_HASH[i];
            end
        end else if (i_ctl.add_en) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_hash_word = r_h[i_ctl.rd_idx];

endmodule

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// sha-256 digest of a byte stream, one byte per transaction, eight
// digest words per message
// ---------------------------------------------------------------------------
//
// channel  direction  handshake                  payload
// -------  ---------  -------------------------  ---------------------------
// in       sink       i_in_valid / o_in_stall    i_data_byte, i_byte_present,
//                                                i_end_of_message
// out      source     o_out_valid / i_out_stall  o_digest_word, o_final_word
//
// a byte that does not complete a block leaves the input ready for the next byte
// a byte that completes a block runs 64 rounds of the shared round unit
// plus one hash update before the next byte is taken
// end of message pushes padding and length one byte per cycle (9 to 72
// bytes), paused for one or two more compressions, then 8 output transactions
// synchronous active low reset restores the initial hash values, zero length
// and an empty buffer
// o_in_stall stays high from a full block until its hash update and from end
// of message until the last digest word is taken, and output stalls simply hold the current word
//
`include "assert_macros.svh"

module sha256_byte_stream_hasher_unit
    import shb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    // digest transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic        o_final_word
);

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;          // bytes gathered in the current block
    logic [63:0] r_bit_count, n_bit_count; // message length, shifted out as length bytes
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_out_idx, n_out_idx;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic        r_ending, n_ending;      // end of message seen, padding due
    logic        r_sent80, n_sent80;      // 0x80 marker already pushed
    logic        r_in_len, n_in_len;      // length bytes in progress
    logic        r_pad_done, n_pad_done;  // last length byte pushed

    t_core_ctl   ctl;
    logic        in_acc;
    logic        out_acc;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bit_count <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_len_cnt   <= '0;
            r_ending    <= 1'b0;
            r_sent80    <= 1'b0;
            r_in_len    <= 1'b0;
            r_pad_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bit_count <= n_bit_count;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_len_cnt   <= n_len_cnt;
            r_ending    <= n_ending;
            r_sent80    <= n_sent80;
            r_in_len    <= n_in_len;
            r_pad_done  <= n_pad_done;
        end
    end

    // sequencer: gather bytes, run rounds, pad, hand out the digest
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bit_count = r_bit_count;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_len_cnt   = r_len_cnt;
        n_ending    = r_ending;
        n_sent80    = r_sent80;
        n_in_len    = r_in_len;
        n_pad_done  = r_pad_done;
        ctl         = '0;
        ctl.round_idx = r_round;
        ctl.rd_idx    = r_out_idx;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        ctl.shift_byte = 1'b1;
                        ctl.byte_val   = i_data_byte;
                        n_bit_count    = r_bit_count + 64'd8;
                    end
                    if (i_end_of_message) begin
                        n_ending = 1'b1;
                    end
                    if (i_byte_present && r_fill == LAST_FILL) begin
                        n_state = ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                ctl.round_en = 1'b1;
                n_round      = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                ctl.add_en = 1'b1;
                if (!r_ending) begin
                    n_state = ST_IDLE;
                end else if (r_pad_done) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                ctl.shift_byte = 1'b1;
                if (!r_sent80) begin
                    ctl.byte_val = PAD_BYTE;
                    n_sent80     = 1'b1;
                end else if (r_in_len || r_fill == LEN_START_FILL) begin
                    // big-endian length, top byte first
                    ctl.byte_val = r_bit_count[63:56];
                    n_bit_count  = {r_bit_count[55:0], 8'h00};
                    n_in_len     = 1'b1;
                    n_len_cnt    = r_len_cnt + 3'd1;
                    if (r_len_cnt == LAST_LEN_BYTE) begin
                        n_pad_done = 1'b1;
                    end
                end else begin
                    ctl.byte_val = 8'h00;
                end
                if (r_fill == LAST_FILL) begin
                    n_state = ST_ROUND;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == LAST_WORD) begin
                        // back to a fresh message
                        ctl.hash_init = 1'b1;
                        n_bit_count   = '0;
                        n_len_cnt     = '0;
                        n_ending      = 1'b0;
                        n_sent80      = 1'b0;
                        n_in_len      = 1'b0;
                        n_pad_done    = 1'b0;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (ctl.shift_byte) begin
            n_fill = r_fill + 6'd1;
        end
    end

    shb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_hash_word (o_digest_word)
    );

    assign o_final_word = (r_out_idx == LAST_WORD);

    // the round loop always runs all 64 rounds
    `SHB_ASSERT_PROP(a_round_run, (r_state == ST_ROUND && r_round != LAST_ROUND) |=> (r_state == ST_ROUND), "round loop left early")
    // the digest only appears after a fully padded message
    `SHB_ASSERT_PROP(a_out_entry, (r_state == ST_OUT && $past(r_state) != ST_OUT) |-> (r_fill == '0 && r_pad_done && r_out_idx == '0), "digest out before padding complete")
    // last digest word returns the block to an empty message
    `SHB_ASSERT_PROP(a_msg_restart, (out_acc && o_final_word) |=> (r_state == ST_IDLE && r_fill == '0 && r_bit_count == '0 && !r_ending), "no clean restart after digest")
    // length bytes occupy the final eight places of a block
    `SHB_ASSERT_NEVER(a_len_place, r_state == ST_PAD && r_in_len && r_fill < LEN_START_FILL, "length byte outside block tail")

endmodule

// ===== tb/tb_sha256_byte_stream_hasher_unit.sv =====
// ---------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_unit
// self-checking bench: byte transactions go in, each digest word that comes
// out is compared against a sha-256 computed alongside in the bench
// ---------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_unit;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int IDLE_PCT      = 9;
    localparam int NOISE_PCT     = 10;
    // window with no idling on either side
    localparam int QUIET_FROM    = 500;
    localparam int QUIET_TO      = 1300;
    localparam int SETTLE_CYCLES = 200;
    // message index in the random part before which the sender drains
    localparam int DRAIN_MSG     = 6;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [6:0] LEN_FIELD_AT = 7'd56;
    localparam logic [6:0] BLOCK_BYTES  = 7'd64;

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one input transaction; hold makes the sender wait until all
    // outstanding digest words have come back before offering it
    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       hold;
    } t_byte_txn;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } t_digest_word;

    // ---------------------------------------------------------------------
    // clock, reset and dut signals, the driven ones known from time zero
    // ---------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  in_data    = 8'h00;
    logic        in_present = 1'b0;
    logic        in_eom     = 1'b0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] out_word;
    logic        out_final;

    // ---------------------------------------------------------------------
    // bench bookkeeping
    // ---------------------------------------------------------------------
    t_byte_txn    byte_q [$];
    t_digest_word digest_q [$];
    int           cycle_count   = 0;
    int           issue_count   = 0;
    int           accept_count  = 0;
    int           err_count     = 0;
    int           words_checked = 0;
    int           msgs_done     = 0;
    int           bytes_done    = 0;
    logic         quiet;

    // shadow hash state of the bench
    logic [31:0]  chain_val [8];
    logic [7:0]   blk_byte [64];
    logic [6:0]   blk_fill;
    logic [63:0]  msg_bits;

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    sha256_byte_stream_hasher_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (in_data),
        .i_byte_present   (in_present),
        .i_end_of_message (in_eom),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_digest_word    (out_word),
        .o_final_word     (out_final)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // sha-256 of the bench
    // ---------------------------------------------------------------------
    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {blk_byte[4*t], blk_byte[4*t+1], blk_byte[4*t+2], blk_byte[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = chain_val[0]; b = chain_val[1]; c = chain_val[2]; d = chain_val[3];
        e = chain_val[4]; f = chain_val[5]; g = chain_val[6]; h = chain_val[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + RND_CONST[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_val[0] += a; chain_val[1] += b; chain_val[2] += c; chain_val[3] += d;
        chain_val[4] += e; chain_val[5] += f; chain_val[6] += g; chain_val[7] += h;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        blk_byte[blk_fill[5:0]] = b;
        blk_fill = blk_fill + 7'd1;
        if (blk_fill == BLOCK_BYTES) begin
            compress_block();
            blk_fill = '0;
        end
    endtask

    task automatic restart_digest();
        chain_val = H_START;
        msg_bits  = '0;
        blk_fill  = '0;
    endtask

    // absorbs one accepted transaction, queues eight words on end of message
    task automatic hash_txn(input logic [7:0] d, input logic p, input logic e);
        logic [63:0]  total;
        t_digest_word dw;
        if (p) begin
            absorb_byte(d);
            msg_bits = msg_bits + 64'd8;
            bytes_done++;
        end
        if (e) begin
            total = msg_bits;
            absorb_byte(PAD_MARK);
            while (blk_fill != LEN_FIELD_AT) absorb_byte(8'h00);
            for (int k = 0; k < 8; k++) absorb_byte(total[63 - 8*k -: 8]);
            for (int k = 0; k < 8; k++) begin
                dw.word = chain_val[k];
                dw.last = (k == 7);
                digest_q.insert(digest_q.size(), dw);
            end
            restart_digest();
            msgs_done++;
        end
    endtask

    task automatic queue_txn(input logic [7:0] d, input logic p, input logic e,
                             input logic hold);
        t_byte_txn item;
        item.data    = d;
        item.present = p;
        item.eom     = e;
        item.hold    = hold;
        byte_q.insert(byte_q.size(), item);
    endtask

    // ---------------------------------------------------------------------
    // monitor: everything sampled at the rising edge
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_digest_word want;
        cycle_count++;
        if (rst_n) begin
            // digest transaction first: it can never stem from a byte taken
            // at this same edge
            if (out_valid && !out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %08h (final %0b)", out_word, out_final);
                    err_count++;
                end else begin
                    want = digest_q.pop_front();
                    if (out_word !== want.word) begin
                        $error("digest_word: expected %08h, got %08h", want.word, out_word);
                        err_count++;
                    end
                    if (out_final !== want.last) begin
                        $error("final_word: expected %0b, got %0b", want.last, out_final);
                        err_count++;
                    end
                    words_checked++;
                end
            end
            if (in_valid && !in_stall) begin
                hash_txn(in_data, in_present, in_eom);
                accept_count++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // driver: inputs change at the falling edge only
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_byte_txn nxt;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            // a transaction on offer stays put until it is taken
            if (!in_valid || accept_count == issue_count) begin
                if (byte_q.size() == 0
                        || (byte_q[0].hold && digest_q.size() != 0)
                        || (!quiet && $urandom_range(0, 99) < IDLE_PCT)) begin
                    in_valid <= 1'b0;
                end else begin
                    nxt = byte_q.pop_front();
                    in_valid   <= 1'b1;
                    in_data    <= nxt.data;
                    in_present <= nxt.present;
                    in_eom     <= nxt.eom;
                    issue_count++;
                end
            end
        end
    end

    // hard stop for a hung block
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_sha256_byte_stream_hasher_unit: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        int   n_random;
        int   msg_idx;
        int   len;
        logic glue;
        n_random = 0;
        msg_idx  = 0;
        restart_digest();
        for (int i = 0; i < 64; i++) blk_byte[i] = 8'h00;

        // directed part
        queue_txn(8'ha5, 1'b0, 1'b0, 1'b0);     // idle transaction, no effect
        queue_txn(8'h00, 1'b0, 1'b1, 1'b0);     // empty message
        queue_txn(8'hff, 1'b0, 1'b1, 1'b0);     // empty again, data ignored
        queue_txn(8'hff, 1'b1, 1'b1, 1'b0);     // byte and end together
        queue_txn(8'h00, 1'b1, 1'b0, 1'b0);     // byte, then end on its own
        queue_txn(8'h5a, 1'b0, 1'b1, 1'b0);
        queue_txn(8'h61, 1'b1, 1'b0, 1'b0);     // "abc"
        queue_txn(8'h62, 1'b1, 1'b0, 1'b0);
        queue_txn(8'h63, 1'b1, 1'b1, 1'b0);
        queue_txn(8'h78, 1'b1, 1'b0, 1'b0);     // idle transaction mid message
        queue_txn(8'hc3, 1'b0, 1'b0, 1'b0);
        queue_txn(8'h79, 1'b1, 1'b1, 1'b0);
        queue_txn(8'h3c, 1'b0, 1'b0, 1'b1);     // sender drains here

        // random messages; first ones sit on the padding boundaries
        while (n_random < RANDOM_ITEMS) begin
            case (msg_idx)
                0: len = 55;    // length field fits the last block
                1: len = 56;    // padding spills into an extra block
                2: len = 64;    // whole block, then a padding-only block
                default: begin
                    if ($urandom_range(0, 99) < 70) len = $urandom_range(0, 12);
                    else len = $urandom_range(50, 70);
                end
            endcase
            if (msg_idx == DRAIN_MSG) begin
                queue_txn(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
                n_random++;
            end
            glue = 1'b0;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < NOISE_PCT) begin
                    queue_txn(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
                    n_random++;
                end
                glue = (i == len - 1) && ($urandom_range(0, 1) == 1);
                queue_txn(8'($urandom_range(0, 255)), 1'b1, glue, 1'b0);
            end
            if (!glue) queue_txn(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
            n_random += len + (glue ? 0 : 1);
            msg_idx++;
        end

        // reset released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || accept_count != issue_count) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d message bytes, %0d digest words compared",
                 msgs_done, bytes_done, words_checked);
        $display("mismatches or stray words seen: %0d", err_count);
        if (err_count == 0) begin
            $display("tb_sha256_byte_stream_hasher_unit: done, clean");
        end else begin
            $display("tb_sha256_byte_stream_hasher_unit: done, errors");
        end
        $finish;
    end

endmodule

// ===== sha256_byte_stream_hasher_unit.f =====
+incdir+rtl
rtl/shb_pkg.sv
rtl/shb_core.sv
rtl/sha256_byte_stream_hasher_unit.sv
tb/tb_sha256_byte_stream_hasher_unit.sv
